>>> hw/rtl/bbc_pkg.sv
// ============================================================================
// Bracket balance checker package
// Shared constants, status codes, kind codes and character decoders.
// ============================================================================
package bbc_pkg;

    // Default number of stack entries.
    localparam int STACK_DEPTH_DEF = 128;

    // Width of the character and of the padded result word.
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int M_DATA_W = 8;

    // Verdict codes, in the order of their numeric values.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_UNCLOSED = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // Bracket kind as stored on the stack.
    typedef logic [1:0] kind_t;

    localparam kind_t KIND_ROUND  = 2'd0;
    localparam kind_t KIND_CURLY  = 2'd1;
    localparam kind_t KIND_SQUARE = 2'd2;
    localparam kind_t KIND_NONE   = 2'd3;

    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28; // (
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B; // {
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B; // [
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29; // )
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D; // }
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D; // ]

    function automatic kind_t opener_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        case (c)
            CH_OPEN_ROUND:  k = KIND_ROUND;
            CH_OPEN_CURLY:  k = KIND_CURLY;
            CH_OPEN_SQUARE: k = KIND_SQUARE;
            default:        k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic kind_t closer_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        case (c)
            CH_CLOSE_ROUND:  k = KIND_ROUND;
            CH_CLOSE_CURLY:  k = KIND_CURLY;
            CH_CLOSE_SQUARE: k = KIND_SQUARE;
            default:         k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

>>> hw/rtl/bbc_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/bracket_balance_checker_top.sv
// ============================================================================
// Bracket balance checker
// Checks nesting of round, curly and square brackets in a character stream.
// ============================================================================
//
//  Channel  | Direction | tdata                      | tlast          | tuser
//  ---------+-----------+----------------------------+----------------+----------
//  s_       | in        | [7:0] character            | end of express.| -
//  m_       | out       | [2:0] status, [7:3] zero   | -              | balanced
//
// The block takes one word per cycle while s_tready is high; every input
// word is processed against a cached top-of-stack register.
// Only the top entry lives in a register; the entries below it sit in a RAM
// with registered read data. Each cycle the RAM is read at the entry
// just beneath the new top, so a pop in the next cycle finds it ready; a
// bypass register covers the case of a push writing that same entry.
// Reset (aresetn low, synchronous) clears the depth, the error and the output
// channel. The RAM needs no clearing pass: only entries pushed during the
// current expression are ever read.
// A verdict waits in an output register with a one-word skid stage behind it,
// so s_tready drops only when both hold a verdict that m_ has not taken.
// ============================================================================
module bracket_balance_checker_top
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata: [7:0] character
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CHAR_W-1:0]   s_tdata,
    input  logic                s_tlast,
    // m_tdata: [2:0] status, [7:3] zero fill
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    // m_tuser: [0] balanced
    output logic                m_tuser
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    // Stack control state.
    logic [DW-1:0] depth_reg, depth_next;
    kind_t         top_reg, top_next;
    status_t       err_reg, err_next;
    logic          fwd_hit_reg, fwd_hit_next;
    kind_t         fwd_data_reg;

    // RAM ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    kind_t         ram_wdata;
    logic [AW-1:0] ram_raddr;
    kind_t         ram_rdata;

    // Output register and skid stage.
    logic          out_valid_reg;
    status_t       out_status_reg;
    logic          skid_valid_reg;
    status_t       skid_status_reg;

    logic          accept;
    logic          verdict_valid;
    status_t       verdict_status;
    kind_t         kind_open;
    kind_t         kind_close;
    kind_t         below;

    assign accept     = s_tvalid && s_tready;
    assign kind_open  = opener_kind(s_tdata);
    assign kind_close = closer_kind(s_tdata);

    // The entry just below the top, either fresh from the RAM or forwarded
    // from a write that hit the address being read.
    assign below = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb begin
        depth_next = depth_reg;
        top_next   = top_reg;
        err_next   = err_reg;
        ram_we     = 1'b0;
        ram_waddr  = AW'(depth_reg - DW'(1));
        ram_wdata  = top_reg;

        if (accept) begin
            if (s_tlast) begin
                // End of expression: start the next one with an empty stack.
                depth_next = '0;
                err_next   = ST_OK;
            end else if (err_reg == ST_OK) begin
                if (kind_open != KIND_NONE) begin
                    if (depth_reg == DW'(STACK_DEPTH)) begin
                        err_next = ST_OVERFLOW;
                    end else begin
                        // The old top moves into the RAM below the new one.
                        ram_we     = (depth_reg != '0);
                        top_next   = kind_open;
                        depth_next = depth_reg + DW'(1);
                    end
                end else if (kind_close != KIND_NONE) begin
                    if (depth_reg == '0) begin
                        err_next = ST_EMPTY;
                    end else begin
                        depth_next = depth_reg - DW'(1);
                        top_next   = below;
                        if (top_reg != kind_close) begin
                            err_next = ST_MISMATCH;
                        end
                    end
                end
            end
        end

        ram_raddr    = AW'(depth_next - DW'(2));
        fwd_hit_next = ram_we && (ram_waddr == ram_raddr);
    end

    bbc_ram #(
        .WIDTH ($bits(kind_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            err_reg     <= ST_OK;
            fwd_hit_reg <= 1'b0;
        end else begin
            depth_reg   <= depth_next;
            err_reg     <= err_next;
            fwd_hit_reg <= fwd_hit_next;
        end
        top_reg      <= top_next;
        fwd_data_reg <= ram_wdata;
    end

    // Verdict of the expression that ends with this word.
    assign verdict_valid  = accept && s_tlast;
    assign verdict_status = (err_reg == ST_OK && depth_reg != '0) ? ST_UNCLOSED : err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= skid_status_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= verdict_valid;
                out_status_reg <= verdict_status;
            end
        end else if (verdict_valid) begin
            // Output is stalled: park the new verdict in the skid stage.
            skid_valid_reg  <= 1'b1;
            skid_status_reg <= verdict_status;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - STATUS_W){1'b0}}, out_status_reg};
    assign m_tuser  = (out_status_reg == ST_OK);

endmodule

>>> hw/rtl/bbc_checker.sv
// ============================================================================
// Bracket balance checker port checks
// Concurrent assertions on the top-level ports, bound to the top level.
// ============================================================================
module bbc_checker
    import bbc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    // No verdict is pending right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("verdict valid after reset");

    // The balanced flag agrees with the status code.
    a_balanced_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata[STATUS_W-1:0] == ST_OK)))
        else $error("balanced flag disagrees with status");

    // Status is a defined code and the fill bits are zero.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_DATA_W-1:STATUS_W] == '0 &&
                      m_tdata[STATUS_W-1:0] <= ST_OVERFLOW))
        else $error("undefined status code");

    // A verdict appears on an idle output only after an end-of-expression word.
    a_verdict_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("verdict without end of expression");

    // A held verdict does not change under backpressure.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("verdict changed while stalled");

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
